>>> rtl/tpqf_pkg.sv
// ----------------------------------------------------------------------------
// Three-point quadratic fit package
// Shared types and constants for the fit front end, queue and back end.
// ----------------------------------------------------------------------------
package tpqf_pkg;

  localparam int XW = 16;   // point position width
  localparam int YW = 16;   // point value width (Q1.15)
  localparam int CW = 64;   // coefficient width
  localparam int DW = 48;   // divisor width, h0 * h1 * hh < 2^48
  localparam int PW = 48;   // unsigned product multiplier width
  localparam int TW = PW + YW + 1;  // signed value times unsigned product
  localparam int SW = 68;   // signed numerator sum width
  localparam int NW = 68;   // shifted numerator magnitude and quotient width
  localparam int CNTW = $clog2(NW);

  // Fractional bits gained by each coefficient before the division.
  localparam int K_SQUARE   = 33;
  localparam int K_LINEAR   = 17;
  localparam int K_CONSTANT = 1;

  typedef enum logic [1:0] {
    MODE_QUAD       = 2'd0,
    MODE_LINE_FIRST = 2'd1,
    MODE_LINE_LAST  = 2'd2,
    MODE_CONST      = 2'd3
  } mode_t;

  typedef struct packed {
    logic        [XW-1:0] x0;
    logic signed [YW-1:0] y0;
    logic        [XW-1:0] x1;
    logic signed [YW-1:0] y1;
    logic        [XW-1:0] x2;
    logic signed [YW-1:0] y2;
    mode_t                mode;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIFF,
    BK_MUL1,
    BK_MUL2,
    BK_MUL3,
    BK_SUM,
    BK_DIV,
    BK_ROUND,
    BK_PUT
  } back_state_t;

endpackage

>>> rtl/tpqf_front.sv
// ----------------------------------------------------------------------------
// Three-point quadratic fit front end
// Accepts point triples and classifies the fit before queueing them.
// ----------------------------------------------------------------------------
module tpqf_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic        [tpqf_pkg::XW-1:0] x_first,
  input  logic signed [tpqf_pkg::YW-1:0] y_first,
  input  logic        [tpqf_pkg::XW-1:0] x_middle,
  input  logic signed [tpqf_pkg::YW-1:0] y_middle,
  input  logic        [tpqf_pkg::XW-1:0] x_last,
  input  logic signed [tpqf_pkg::YW-1:0] y_last,
  input  logic                          q_full,
  output logic                          q_push,
  output tpqf_pkg::item_t               q_item
);

  tpqf_pkg::mode_t mode;

  // Strict ordering alone picks the fit; equal or descending pairs fall through.
  always_comb begin
    if ((x_first < x_middle) && (x_middle < x_last)) begin
      mode = tpqf_pkg::MODE_QUAD;
    end else if (x_first < x_middle) begin
      mode = tpqf_pkg::MODE_LINE_FIRST;
    end else if (x_middle < x_last) begin
      mode = tpqf_pkg::MODE_LINE_LAST;
    end else begin
      mode = tpqf_pkg::MODE_CONST;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.x0   = x_first;
    q_item.y0   = y_first;
    q_item.x1   = x_middle;
    q_item.y1   = y_middle;
    q_item.x2   = x_last;
    q_item.y2   = y_last;
    q_item.mode = mode;
  end

endmodule

>>> rtl/tpqf_queue.sv
// ----------------------------------------------------------------------------
// Three-point quadratic fit queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tpqf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tpqf_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output tpqf_pkg::item_t head
);

  tpqf_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/tpqf_back.sv
// ----------------------------------------------------------------------------
// Three-point quadratic fit back end
// Forms the three exact numerators, divides them in three restoring lanes,
// rounds, saturates and holds the result in an output register.
// ----------------------------------------------------------------------------
module tpqf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  tpqf_pkg::item_t             head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tpqf_pkg::CW-1:0]     coef_square,
  output logic [tpqf_pkg::CW-1:0]     coef_linear,
  output logic [tpqf_pkg::CW-1:0]     coef_constant,
  output logic [1:0]                  fit_mode
);

  localparam int NW = tpqf_pkg::NW;
  localparam int DW = tpqf_pkg::DW;
  localparam int PW = tpqf_pkg::PW;
  localparam int TW = tpqf_pkg::TW;
  localparam int SW = tpqf_pkg::SW;
  localparam int XW = tpqf_pkg::XW;
  localparam int YW = tpqf_pkg::YW;
  localparam int CW = tpqf_pkg::CW;

  function automatic logic [CW-1:0] round_sat(input logic [NW-1:0] q,
                                              input logic [DW-1:0] r,
                                              input logic [DW-1:0] d,
                                              input logic          ng);
    logic          up;
    logic [NW-1:0] qr;
    logic [CW-1:0] res;
    up = ({r, 1'b0} >= {1'b0, d});
    qr = q + NW'(up);
    if (!ng) begin
      res = (|qr[NW-1:CW-1]) ? {1'b0, {(CW-1){1'b1}}} : qr[CW-1:0];
    end else if ((|qr[NW-1:CW]) || (qr[CW-1] && (|qr[CW-2:0]))) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = {CW{1'b0}} - qr[CW-1:0];
    end
    return res;
  endfunction

  tpqf_pkg::back_state_t state, state_next;

  tpqf_pkg::item_t it;
  logic [XW-1:0]   h0, h1, hh;
  logic [XW:0]     s01, s02, s12;
  logic [2*XW-1:0] m_h01, m_x12, m_x02, m_x01;
  logic [2*XW:0]   pb0, pb1, pb2;
  logic [DW-1:0]   dq;
  logic [PW-1:0]   pc0, pc1, pc2;
  logic signed [TW-1:0] term [9];
  logic [DW-1:0]   den;
  logic [NW-1:0]   dvd [3];
  logic [DW-1:0]   rem [3];
  logic            neg [3];
  logic [tpqf_pkg::CNTW-1:0] cnt;
  logic [CW-1:0]   res_sq, res_lin, res_con;

  logic signed [YW-1:0] y_op [9];
  logic [PW-1:0]        p_op [9];
  logic [DW-1:0]        den_sel;
  logic signed [SW-1:0] sum [3];
  logic [NW-1:0]        mag [3];
  logic [DW:0]          tr  [3];
  logic                 ge  [3];
  logic                 out_load;

  // Operand selection: every mode is cast as three signed sums of y * p.
  always_comb begin
    for (int j = 0; j < 9; j++) begin
      y_op[j] = it.y0;
      p_op[j] = '0;
    end
    den_sel = DW'(1);
    case (it.mode)
      tpqf_pkg::MODE_QUAD: begin
        y_op[0] = it.y0; p_op[0] = PW'(h1);
        y_op[1] = it.y1; p_op[1] = PW'(hh);
        y_op[2] = it.y2; p_op[2] = PW'(h0);
        y_op[3] = it.y0; p_op[3] = PW'(pb0);
        y_op[4] = it.y1; p_op[4] = PW'(pb1);
        y_op[5] = it.y2; p_op[5] = PW'(pb2);
        y_op[6] = it.y0; p_op[6] = pc0;
        y_op[7] = it.y1; p_op[7] = pc1;
        y_op[8] = it.y2; p_op[8] = pc2;
        den_sel = dq;
      end
      tpqf_pkg::MODE_LINE_FIRST: begin
        y_op[3] = it.y0; p_op[3] = PW'(1);
        y_op[4] = it.y1; p_op[4] = PW'(1);
        y_op[6] = it.y0; p_op[6] = PW'(it.x1);
        y_op[7] = it.y1; p_op[7] = PW'(it.x0);
        den_sel = DW'(h0);
      end
      tpqf_pkg::MODE_LINE_LAST: begin
        y_op[3] = it.y1; p_op[3] = PW'(1);
        y_op[4] = it.y2; p_op[4] = PW'(1);
        y_op[6] = it.y1; p_op[6] = PW'(it.x2);
        y_op[7] = it.y2; p_op[7] = PW'(it.x1);
        den_sel = DW'(h1);
      end
      default: begin
        y_op[6] = it.y2; p_op[6] = PW'(1);
      end
    endcase
  end

  always_comb begin
    sum[0] = SW'(term[0]) - SW'(term[1]) + SW'(term[2]);
    sum[1] = SW'(term[4]) - SW'(term[3]) - SW'(term[5]);
    sum[2] = SW'(term[6]) - SW'(term[7]) + SW'(term[8]);
    for (int i = 0; i < 3; i++) begin
      mag[i] = sum[i][SW-1] ? NW'(-sum[i]) : NW'(sum[i]);
    end
    for (int i = 0; i < 3; i++) begin
      tr[i] = {rem[i], dvd[i][NW-1]};
      ge[i] = (tr[i] >= {1'b0, den});
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tpqf_pkg::BK_IDLE:  if (q_valid) state_next = tpqf_pkg::BK_DIFF;
      tpqf_pkg::BK_DIFF:  state_next = tpqf_pkg::BK_MUL1;
      tpqf_pkg::BK_MUL1:  state_next = tpqf_pkg::BK_MUL2;
      tpqf_pkg::BK_MUL2:  state_next = tpqf_pkg::BK_MUL3;
      tpqf_pkg::BK_MUL3:  state_next = tpqf_pkg::BK_SUM;
      tpqf_pkg::BK_SUM:   state_next = tpqf_pkg::BK_DIV;
      tpqf_pkg::BK_DIV:   if (cnt == '0) state_next = tpqf_pkg::BK_ROUND;
      tpqf_pkg::BK_ROUND: state_next = tpqf_pkg::BK_PUT;
      tpqf_pkg::BK_PUT:   if (!out_valid || !out_stall) state_next = tpqf_pkg::BK_IDLE;
      default:            state_next = tpqf_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state)
      tpqf_pkg::BK_IDLE: pop      = q_valid;
      tpqf_pkg::BK_PUT:  out_load = !out_valid || !out_stall;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpqf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tpqf_pkg::BK_IDLE: begin
        if (q_valid) begin
          it <= head;
        end
      end
      tpqf_pkg::BK_DIFF: begin
        h0  <= it.x1 - it.x0;
        h1  <= it.x2 - it.x1;
        hh  <= it.x2 - it.x0;
        s01 <= (XW+1)'(it.x0) + (XW+1)'(it.x1);
        s02 <= (XW+1)'(it.x0) + (XW+1)'(it.x2);
        s12 <= (XW+1)'(it.x1) + (XW+1)'(it.x2);
      end
      tpqf_pkg::BK_MUL1: begin
        m_h01 <= h0 * h1;
        m_x12 <= it.x1 * it.x2;
        m_x02 <= it.x0 * it.x2;
        m_x01 <= it.x0 * it.x1;
        pb0   <= s12 * h1;
        pb1   <= s02 * hh;
        pb2   <= s01 * h0;
      end
      tpqf_pkg::BK_MUL2: begin
        dq  <= DW'(m_h01) * DW'(hh);
        pc0 <= PW'(m_x12) * PW'(h1);
        pc1 <= PW'(m_x02) * PW'(hh);
        pc2 <= PW'(m_x01) * PW'(h0);
      end
      tpqf_pkg::BK_MUL3: begin
        for (int j = 0; j < 9; j++) begin
          term[j] <= y_op[j] * $signed({1'b0, p_op[j]});
        end
        den <= den_sel;
      end
      tpqf_pkg::BK_SUM: begin
        dvd[0] <= mag[0] << tpqf_pkg::K_SQUARE;
        dvd[1] <= mag[1] << tpqf_pkg::K_LINEAR;
        dvd[2] <= mag[2] << tpqf_pkg::K_CONSTANT;
        for (int i = 0; i < 3; i++) begin
          rem[i] <= '0;
          neg[i] <= sum[i][SW-1];
        end
        cnt <= tpqf_pkg::CNTW'(NW - 1);
      end
      tpqf_pkg::BK_DIV: begin
        // One quotient bit per lane and cycle; the dividend shifts out as the
        // quotient shifts in.
        for (int i = 0; i < 3; i++) begin
          rem[i] <= ge[i] ? DW'(tr[i] - {1'b0, den}) : tr[i][DW-1:0];
          dvd[i] <= {dvd[i][NW-2:0], ge[i]};
        end
        cnt <= cnt - 1'b1;
      end
      tpqf_pkg::BK_ROUND: begin
        res_sq  <= round_sat(dvd[0], rem[0], den, neg[0]);
        res_lin <= round_sat(dvd[1], rem[1], den, neg[1]);
        res_con <= round_sat(dvd[2], rem[2], den, neg[2]);
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      coef_square   <= res_sq;
      coef_linear   <= res_lin;
      coef_constant <= res_con;
      fit_mode      <= it.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == tpqf_pkg::BK_DIV) |-> (rem[0] < den && rem[1] < den && rem[2] < den))
    else $error("divider remainder reached the divisor");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == tpqf_pkg::BK_DIV) |-> (den != '0))
    else $error("division started with a zero divisor");

  a_put_loads: assert property (@(posedge clk) disable iff (rst)
    (state == tpqf_pkg::BK_PUT && (!out_valid || !out_stall)) |=>
      (out_valid && state == tpqf_pkg::BK_IDLE))
    else $error("finished result was not moved to the output register");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == tpqf_pkg::BK_DIFF))
    else $error("queue popped without starting a fit");

endmodule

>>> rtl/three_point_quadratic_fit.sv
// ----------------------------------------------------------------------------
// Three-point quadratic fit
// The back end works on one transaction at a time; the next one is popped only
// after the 68 one-bit steps of the three restoring divider lanes plus the
// operand and rounding steps, and once the output register has taken the result.
// The two-entry queue takes two more transactions while a fit is running.
// Reset (rst, synchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
module three_point_quadratic_fit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic        [tpqf_pkg::XW-1:0] x_first,
  input  logic signed [tpqf_pkg::YW-1:0] y_first,
  input  logic        [tpqf_pkg::XW-1:0] x_middle,
  input  logic signed [tpqf_pkg::YW-1:0] y_middle,
  input  logic        [tpqf_pkg::XW-1:0] x_last,
  input  logic signed [tpqf_pkg::YW-1:0] y_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [tpqf_pkg::CW-1:0] coef_square,
  output logic signed [tpqf_pkg::CW-1:0] coef_linear,
  output logic signed [tpqf_pkg::CW-1:0] coef_constant,
  output logic        [1:0]              fit_mode
);

  // The front end decides which fit applies from the strict ordering of the
  // positions: a parabola when all three ascend, otherwise a line through
  // the first or the last pair, otherwise the constant through the last value.
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  tpqf_pkg::item_t q_item;
  tpqf_pkg::item_t q_head;

  logic [tpqf_pkg::CW-1:0] sq, lin, con;

  tpqf_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .x_first  (x_first),
    .y_first  (y_first),
    .x_middle (x_middle),
    .y_middle (y_middle),
    .x_last   (x_last),
    .y_last   (y_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  // The queue lets the front end keep taking transactions while the back
  // end is busy dividing or its result waits for the consumer.
  tpqf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  // The back end forms the exact numerators and divisor, divides each
  // coefficient once, rounds to nearest with ties away from zero and
  // saturates to 64 bits. Its output register parts it from the consumer.
  tpqf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .coef_square   (sq),
    .coef_linear   (lin),
    .coef_constant (con),
    .fit_mode      (fit_mode)
  );

  assign coef_square   = $signed(sq);
  assign coef_linear   = $signed(lin);
  assign coef_constant = $signed(con);

endmodule
